>>> rtl/core/rmd_pkg.sv
// shared types and constants for the record marker deframer
`timescale 1ns / 1ps

package rmd_pkg;

    localparam int LENGTH_BITS_DEF = 48;
    localparam int FIELD_W         = 48;
    localparam int CFG_DATA_W      = 48;
    localparam int CFG_ADDR_W      = 2;
    localparam int MARKER_W        = 64;
    localparam int SHORT_MARKER_BYTES = 4;
    localparam int LONG_MARKER_BYTES  = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_MARKER_EIGHT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIG_ENDIAN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STREAM_LEN   = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd1;
    localparam logic [1:0] ST_MISMATCH   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

    typedef struct packed {
        logic       stream_end;
        logic [7:0] data_byte;
    } rmd_in_t;

    typedef struct packed {
        logic               final_result;
        logic [FIELD_W-1:0] payload_length;
        logic [FIELD_W-1:0] payload_offset;
        logic [1:0]         status;
    } rmd_out_t;

endpackage

>>> rtl/core/record_marker_deframer.sv
// Accepts one stream byte per cycle when neither side stalls; each accepted
// byte is held in the input register and any result it makes goes to the
// result register. The rate is set by the per-byte update of the marker shift
// register, payload down-counter and stream position counter, all between the
// input and result registers. Bytes that neither complete a record nor end the
// stream produce no result. Configuration writes take effect at once and must
// be made by the user only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module record_marker_deframer
    import rmd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rmd_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rmd_out_t              m_data
);

    localparam logic [1:0] PH_LEAD    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_TRAIL   = 2'd2;
    localparam logic [1:0] PH_DROP    = 2'd3;

    // configuration
    logic                  eight_reg;
    logic                  big_reg;
    logic [FIELD_W-1:0]    slen_reg;

    // input register and result register
    logic                  in_valid_reg;
    rmd_in_t               in_reg;
    logic                  m_valid_reg;
    rmd_out_t              m_data_reg;

    // framing state
    logic [1:0]            phase_reg,  phase_next;
    logic [2:0]            idx_reg,    idx_next;
    logic [MARKER_W-1:0]   lead_reg,   lead_next;
    logic [MARKER_W-1:0]   trail_reg,  trail_next;
    logic [LENGTH_BITS-1:0] rem_reg,   rem_next;
    logic [LENGTH_BITS-1:0] pos_reg,   pos_next;
    logic [LENGTH_BITS-1:0] start_reg, start_next;

    logic                  advance;
    logic [MARKER_W-1:0]   raw;
    logic [MARKER_W-1:0]   rev8;
    logic [31:0]           rev4;
    logic [31:0]           dec32;
    logic [MARKER_W-1:0]   marker_val;
    logic                  marker_done;
    logic                  too_big;
    logic [LENGTH_BITS-1:0] pos_inc;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [3:0]            marker_bytes;
    logic                  emit;
    logic [1:0]            st;
    logic [LENGTH_BITS-1:0] off;
    logic [MARKER_W-1:0]   off_wide;
    logic [MARKER_W-1:0]   len_wide;
    rmd_out_t              out_next;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // marker decode, latest byte in the low byte of raw
    assign raw = {trail_reg[MARKER_W-9:0], in_reg.data_byte};

    always_comb begin
        for (int k = 0; k < LONG_MARKER_BYTES; k++) begin
            rev8[8*k +: 8] = raw[8*(LONG_MARKER_BYTES-1-k) +: 8];
        end
        for (int k = 0; k < SHORT_MARKER_BYTES; k++) begin
            rev4[8*k +: 8] = raw[8*(SHORT_MARKER_BYTES-1-k) +: 8];
        end
    end

    assign dec32        = big_reg ? raw[31:0] : rev4;
    assign marker_val   = eight_reg ? (big_reg ? raw : rev8) : {{32{dec32[31]}}, dec32};
    assign marker_bytes = eight_reg ? 4'(LONG_MARKER_BYTES) : 4'(SHORT_MARKER_BYTES);
    assign marker_done  = ({1'b0, idx_reg} + 4'd1) >= marker_bytes;
    assign too_big      = marker_val[MARKER_W-1]
                          || (marker_val > {{(MARKER_W-FIELD_W){1'b0}}, slen_reg})
                          || ((marker_val >> LENGTH_BITS) != '0);
    assign pos_inc      = pos_reg + LENGTH_BITS'(1);
    assign rem_dec      = rem_reg - LENGTH_BITS'(1);

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        lead_next  = lead_reg;
        trail_next = trail_reg;
        rem_next   = rem_reg;
        start_next = start_reg;
        pos_next   = pos_inc;
        emit       = 1'b0;
        st         = ST_OK;
        off        = '0;
        len_wide   = '0;

        case (phase_reg)
            PH_LEAD: begin
                trail_next = raw;
                if (marker_done) begin
                    lead_next  = marker_val;
                    trail_next = '0;
                    idx_next   = '0;
                    if (too_big) begin
                        emit       = 1'b1;
                        st         = ST_BAD_LENGTH;
                        off        = pos_inc;
                        len_wide   = marker_val;
                        phase_next = PH_DROP;
                    end else begin
                        start_next = pos_inc;
                        rem_next   = marker_val[LENGTH_BITS-1:0];
                        phase_next = (marker_val != '0) ? PH_PAYLOAD : PH_TRAIL;
                    end
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = PH_TRAIL;
                    idx_next   = '0;
                    trail_next = '0;
                end
            end
            PH_TRAIL: begin
                trail_next = raw;
                if (marker_done) begin
                    emit       = 1'b1;
                    st         = (marker_val == lead_reg) ? ST_OK : ST_MISMATCH;
                    off        = start_reg;
                    len_wide   = lead_reg;
                    phase_next = (marker_val == lead_reg) ? PH_LEAD : PH_DROP;
                    idx_next   = '0;
                    trail_next = '0;
                    lead_next  = '0;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            default: begin
            end
        endcase

        // last byte of the stream: report a cut record unless a result or drop is already due, then re-arm
        if (in_reg.stream_end) begin
            if (!emit && phase_next != PH_DROP) begin
                emit     = 1'b1;
                st       = ST_TRUNCATED;
                off      = '0;
                len_wide = '0;
            end
            phase_next = PH_LEAD;
            idx_next   = '0;
            lead_next  = '0;
            trail_next = '0;
            rem_next   = '0;
            pos_next   = '0;
            start_next = '0;
        end
    end

    assign off_wide = MARKER_W'(off);

    always_comb begin
        out_next.status         = st;
        out_next.payload_offset = off_wide[FIELD_W-1:0];
        out_next.payload_length = len_wide[FIELD_W-1:0];
        out_next.final_result   = in_reg.stream_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eight_reg <= 1'b0;
            big_reg   <= 1'b0;
            slen_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MARKER_EIGHT: eight_reg <= cfg_wdata[0];
                CFG_BIG_ENDIAN:   big_reg   <= cfg_wdata[0];
                CFG_STREAM_LEN:   slen_reg  <= cfg_wdata[FIELD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_LEAD;
            idx_reg      <= '0;
            lead_reg     <= '0;
            trail_reg    <= '0;
            rem_reg      <= '0;
            pos_reg      <= '0;
            start_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= emit;
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                lead_reg    <= lead_next;
                trail_reg   <= trail_next;
                rem_reg     <= rem_next;
                pos_reg     <= pos_next;
                start_reg   <= start_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance && emit) begin
            m_data_reg <= out_next;
        end
    end

    // a cut record carries no offset or length and always ends the stream
    a_trunc_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_TRUNCATED |->
            m_data.payload_offset == '0 && m_data.payload_length == '0
            && m_data.final_result)
        else $error("truncated result with nonzero fields");

    // a good record always hands back to leading marker search
    a_ok_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit && st == ST_OK |=> phase_reg == PH_LEAD)
        else $error("good record did not return to marker search");

    // payload phase never sits on an empty counter
    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> rem_reg != '0)
        else $error("payload phase with zero bytes left");

endmodule
